>>> src/clock_page_replacement_top_assert.svh
// Assertion macros for the clock page replacement block.
// Used by the checker that is bound to the top level; needs nothing else.
`ifndef CLOCK_PAGE_REPLACEMENT_TOP_ASSERT_SVH
`define CLOCK_PAGE_REPLACEMENT_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define CPR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/cpr_pkg.sv
// Shared types and constants of the clock page replacement block.
// No dependencies; the top level, the sweep engine and the checker import it.
`default_nettype none

package cpr_pkg;

    // Field widths of the channels and the configuration register.
    localparam int FRAME_W = 6;
    localparam int CFG_W   = 7;

    // Width used for compares between fields and the frame limit (up to 4096).
    localparam int CMP_W = 13;

    // Ring size after reset.
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // Request type codes.
    localparam logic REQ_TOUCH  = 1'b0;
    localparam logic REQ_VICTIM = 1'b1;

    // Command from the top level to the sweep engine.
    typedef struct packed {
        logic               valid;
        logic               req_type;
        logic [FRAME_W-1:0] frame_index;
    } t_cpr_cmd;

    // Result from the sweep engine to the output register.
    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] victim_index;
    } t_cpr_res;

endpackage

`default_nettype wire

>>> src/cpr_ifs.sv
// Valid/ready channel interfaces for requests and victim results.
// Depends on nothing; used by the top level.
`default_nettype none

// Request channel: touch or victim request.
interface cpr_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [5:0] frame_index;

    modport source (output valid, output req_type, output frame_index, input ready);
    modport sink   (input valid, input req_type, input frame_index, output ready);
endinterface

// Result channel: chosen victim frame.
interface cpr_res_if;
    logic       valid;
    logic       ready;
    logic [5:0] victim_index;

    modport source (output valid, output victim_index, input ready);
    modport sink   (input valid, input victim_index, output ready);
endinterface

`default_nettype wire

>>> src/clock_page_replacement_top.sv
// Top level of the clock page replacement block: configuration, ring clamp, output register.
// Depends on cpr_pkg, cpr_ifs (cpr_req_if, cpr_res_if) and cpr_sweep.
//
// Usage:
//   i_req carries requests. A touch (req_type 0) sets the accessed bit of frame_index
//   and gives no result. A victim request (req_type 1) sweeps the ring from the clock
//   hand, clearing accessed bits, and gives one transfer on o_res. The frames are
//   read in turn through the single read port of the accessed-bit memory, whose
//   read is registered; the first unaccessed frame found is the victim, and if all
//   frames of the ring were accessed the victim is the starting frame. The result
//   passes from the DONE state into the output register, and the next request can
//   be accepted once it has. One request is worked on at a time; i_req.ready is low
//   while a sweep runs.
//   i_cfg_we writes the ring size (frames 0 .. i_cfg_wdata-1, zero taken as one,
//   sizes above MAX_FRAMES taken as MAX_FRAMES); write it only while the block is idle.
//   After reset the ring size is 64, the hand is zero, and a clearing pass over all
//   MAX_FRAMES frames zeroes the accessed bits; no request is accepted during it.
//   If the receiver stalls o_res, the result is held in the output register and the
//   block still accepts requests; a further victim result waits until it drains.
`default_nettype none

module clock_page_replacement_top #(
    parameter int MAX_FRAMES = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    cpr_req_if.sink                    i_req,
    cpr_res_if.source                  o_res,
    input  logic                       i_cfg_we,
    input  logic [cpr_pkg::CFG_W-1:0]  i_cfg_wdata
);
    import cpr_pkg::*;

    localparam int RING_W = $clog2(MAX_FRAMES + 1);
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_FRAMES);

    logic [CFG_W-1:0]    r_frames_in_use;
    logic [RING_W-1:0]   ring;
    t_cpr_cmd            cmd;
    logic                cmd_ready;
    t_cpr_res            res;
    logic                res_ready;
    logic                r_out_valid;
    logic [FRAME_W-1:0]  r_out_victim;

    // Ring size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_frames_in_use <= i_cfg_wdata;
        end
    end

    // Clamp the ring size to one .. MAX_FRAMES.
    always_comb begin
        if (r_frames_in_use == '0) begin
            ring = RING_W'(1);
        end else if (CMP_W'(r_frames_in_use) > MAX_CMP) begin
            ring = RING_W'(MAX_FRAMES);
        end else begin
            ring = RING_W'(r_frames_in_use);
        end
    end

    // Request channel into the sweep engine.
    assign cmd.valid       = i_req.valid;
    assign cmd.req_type    = i_req.req_type;
    assign cmd.frame_index = i_req.frame_index;
    assign i_req.ready     = cmd_ready;

    cpr_sweep #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_sweep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .i_ring      (ring),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // Output register: takes a result when empty or being drained this cycle.
    assign res_ready = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && res_ready) begin
            r_out_victim <= res.victim_index;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.victim_index = r_out_victim;

endmodule

`default_nettype wire

>>> src/cpr_sweep.sv
// Sweep engine: accessed-bit memory, clock hand and the read-modify-write scan.
// Depends on cpr_pkg.
`default_nettype none

module cpr_sweep #(
    parameter int MAX_FRAMES = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cpr_pkg::t_cpr_cmd                 i_cmd,
    output logic                              o_cmd_ready,
    input  logic [$clog2(MAX_FRAMES+1)-1:0]   i_ring,
    output cpr_pkg::t_cpr_res                 o_res,
    input  logic                              i_res_ready
);
    import cpr_pkg::*;

    localparam int IDX_W  = $clog2(MAX_FRAMES);
    localparam int RING_W = $clog2(MAX_FRAMES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_FRAMES - 1);
    localparam logic [CMP_W-1:0] MAX_CMP  = CMP_W'(MAX_FRAMES);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state               r_state;
    logic [IDX_W-1:0]     r_clr_addr;
    logic [FRAME_W-1:0]   r_hand;
    logic [IDX_W-1:0]     r_next;
    logic [RING_W-1:0]    r_left;
    logic                 r_pend;
    logic [IDX_W-1:0]     r_pend_addr;
    logic [IDX_W-1:0]     r_start;
    logic [RING_W-1:0]    r_ring;
    logic [FRAME_W-1:0]   r_victim;

    logic                 r_mem [MAX_FRAMES];
    logic                 r_rd_data;

    logic                 cmd_acc;
    logic                 hand_in_ring;
    logic [IDX_W-1:0]     start_idx;
    logic                 touch_ok;
    logic [RING_W-1:0]    next_inc;
    logic [IDX_W-1:0]     next_wrap;
    logic                 issue;
    logic                 resolve;
    logic                 scan_clear;
    logic [IDX_W-1:0]     victim_sel;
    logic [RING_W-1:0]    vic_inc;
    logic [RING_W-1:0]    hand_next;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic                 mem_wdata;

    // Handshake towards the top level.
    assign o_cmd_ready      = (r_state == ST_IDLE);
    assign cmd_acc          = i_cmd.valid && (r_state == ST_IDLE);
    assign o_res.valid        = (r_state == ST_DONE);
    assign o_res.victim_index = r_victim;

    // Starting frame of a sweep: the hand, or frame zero if the ring has shrunk below it.
    assign hand_in_ring = CMP_W'(r_hand) < CMP_W'(i_ring);
    assign start_idx    = hand_in_ring ? IDX_W'(r_hand) : '0;
    assign touch_ok     = CMP_W'(i_cmd.frame_index) < MAX_CMP;

    // Next read address around the ring.
    assign next_inc  = RING_W'(r_next) + RING_W'(1);
    assign next_wrap = (next_inc == r_ring) ? '0 : IDX_W'(next_inc);

    // Scan control: one read a cycle, data checked the cycle after.
    assign issue      = (r_state == ST_SCAN) && (r_left != '0);
    assign resolve    = (r_state == ST_SCAN) && r_pend && (!r_rd_data || (r_left == '0));
    assign scan_clear = (r_state == ST_SCAN) && r_pend && r_rd_data;

    // An unaccessed frame is the victim; after a full clearing sweep it is the start.
    assign victim_sel = r_rd_data ? r_start : r_pend_addr;
    assign vic_inc    = RING_W'(victim_sel) + RING_W'(1);
    assign hand_next  = (vic_inc == r_ring) ? '0 : vic_inc;

    // Write port: clearing pass, touch, or clearing a passed-over frame.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_pend_addr;
        mem_wdata = 1'b0;
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
        end else if (cmd_acc && (i_cmd.req_type == REQ_TOUCH) && touch_ok) begin
            mem_we    = 1'b1;
            mem_waddr = IDX_W'(i_cmd.frame_index);
            mem_wdata = 1'b1;
        end else if (scan_clear) begin
            mem_we    = 1'b1;
        end
    end

    // Accessed-bit memory, one write and one registered read a cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (issue) begin
            r_rd_data <= r_mem[r_next];
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_hand     <= '0;
            r_pend     <= 1'b0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + IDX_W'(1);
                    if (r_clr_addr == LAST_IDX) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (cmd_acc && (i_cmd.req_type == REQ_VICTIM)) begin
                        r_ring  <= i_ring;
                        r_start <= start_idx;
                        r_next  <= start_idx;
                        r_left  <= i_ring;
                        r_pend  <= 1'b0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_pend      <= issue && !resolve;
                    r_pend_addr <= r_next;
                    if (issue) begin
                        r_next <= next_wrap;
                        r_left <= r_left - RING_W'(1);
                    end
                    if (resolve) begin
                        r_victim <= FRAME_W'(victim_sel);
                        r_hand   <= FRAME_W'(hand_next);
                        r_state  <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (i_res_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/cpr_checker.sv
// Port-level checker for the clock page replacement block, with its bind statement.
// Depends on cpr_pkg and clock_page_replacement_top_assert.svh.
`default_nettype none

`include "clock_page_replacement_top_assert.svh"

module cpr_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic        i_req_type,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [5:0]  i_victim_index
);
    import cpr_pkg::*;

    // A stalled result stays offered and unchanged.
    `CPR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_victim_index), "stalled result changed or dropped")

    // A victim request occupies the block for at least the next cycle.
    `CPR_ASSERT_NEXT(a_victim_busy, i_clk, i_rst_n, i_req_valid && i_req_ready && (i_req_type == REQ_VICTIM), !i_req_ready, "ready during a sweep")

    // A touch leaves the block ready in the cycle after it.
    `CPR_ASSERT_NEXT(a_touch_single, i_clk, i_rst_n, i_req_valid && i_req_ready && (i_req_type == REQ_TOUCH), i_req_ready, "touch did not complete in one cycle")

    // The clearing pass after reset holds off requests.
    `CPR_ASSERT_NOW(a_clear_after_reset, i_clk, i_rst_n, $past(!i_rst_n), !i_req_ready, "request taken during clearing pass")

endmodule

bind clock_page_replacement_top cpr_checker u_cpr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_req_type     (i_req.req_type),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_victim_index (o_res.victim_index)
);

`default_nettype wire
